// File: src/rfpt_pkg.sv
// Shared types, constants and fixed-point helpers for the rod frame transport pipeline.
`default_nettype none

package rfpt_pkg;

    localparam int FRAC_BITS   = 14;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_W       = 32 + FRAC_BITS;
    localparam int NORM_LAT    = SQRT_STAGES + DIV_W + 4;

    localparam logic signed [63:0] INT_LIM = 64'sd2147483647;
    localparam logic signed [63:0] OUT_LIM =
        (FRAC_BITS >= 15) ? 64'sd32767 : (64'sd1 <<< FRAC_BITS);

    typedef logic signed [15:0] t_q16;
    typedef logic signed [31:0] t_q32;
    typedef logic signed [47:0] t_p48;
    typedef logic signed [63:0] t_p64;
    typedef t_q16 [2:0] t_vec16;
    typedef t_q32 [2:0] t_vec32;

    typedef struct packed {
        t_vec16 d;
        t_vec16 t1;
        t_vec16 t2;
        logic   last;
        logic   par;
    } t_side;

    // Shift right by the fraction width, rounding half away from zero.
    function automatic t_p64 rescale(input t_p64 v);
        logic [63:0] mag;
        logic [63:0] res;
        mag = v[63] ? (64'd0 - $unsigned(v)) : $unsigned(v);
        res = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[63] ? $signed(64'd0 - res) : $signed(res);
    endfunction

    function automatic t_q32 sat_int(input t_p64 v);
        t_q32 res;
        if (v > INT_LIM) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -INT_LIM) begin
            res = 32'sh80000001;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic t_q16 sat_out(input t_p64 v);
        t_q16 res;
        if (v > OUT_LIM) begin
            res = $signed(OUT_LIM[15:0]);
        end else if (v < -OUT_LIM) begin
            res = $signed(16'd0 - OUT_LIM[15:0]);
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: src/rfpt_norm.sv
// Pipelined vector normalizer: square sum, bit-per-stage square root, bit-per-stage divide.
`default_nettype none

module rfpt_norm import rfpt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_vec32 i_vec,
    input  t_side  i_side,
    output logic   o_valid,
    output t_vec32 o_vec,
    output t_side  o_side
);

    typedef logic [31:0] t_mag;
    typedef t_mag [2:0] t_mag3;
    typedef logic [DIV_W-1:0] t_num;
    typedef t_num [2:0] t_num3;

    t_mag3 w_mag;

    logic              r_q_v;
    t_mag3             r_q_m;
    logic [2:0]        r_q_neg;
    logic [2:0][63:0]  r_q_sq;
    t_side             r_q_side;

    logic        r_t_v    [SQRT_STAGES+1];
    logic [63:0] r_t_n    [SQRT_STAGES+1];
    logic [63:0] r_t_r    [SQRT_STAGES+1];
    t_mag3       r_t_m    [SQRT_STAGES+1];
    logic [2:0]  r_t_neg  [SQRT_STAGES+1];
    t_side       r_t_side [SQRT_STAGES+1];

    logic        r_d_v    [DIV_W+1];
    logic [31:0] r_d_s    [DIV_W+1];
    t_num3       r_d_num  [DIV_W+1];
    t_mag3       r_d_rem  [DIV_W+1];
    t_num3       r_d_quo  [DIV_W+1];
    logic [2:0]  r_d_neg  [DIV_W+1];
    t_side       r_d_side [DIV_W+1];

    logic   r_o_v;
    t_vec32 r_o_vec;
    t_side  r_o_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = i_vec[i][31] ? (32'd0 - $unsigned(i_vec[i])) : $unsigned(i_vec[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v <= 1'b0;
        end else begin
            r_q_v <= i_valid;
        end
        for (int i = 0; i < 3; i++) begin
            r_q_sq[i]  <= w_mag[i] * w_mag[i];
            r_q_neg[i] <= i_vec[i][31];
        end
        r_q_m    <= w_mag;
        r_q_side <= i_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_v[0] <= 1'b0;
        end else begin
            r_t_v[0] <= r_q_v;
        end
        r_t_n[0]    <= r_q_sq[0] + r_q_sq[1] + r_q_sq[2];
        r_t_r[0]    <= 64'd0;
        r_t_m[0]    <= r_q_m;
        r_t_neg[0]  <= r_q_neg;
        r_t_side[0] <= r_q_side;
    end

    // One result bit of the integer square root per stage.
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
        localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
        logic [63:0] w_trial;
        assign w_trial = r_t_r[k] + BITV;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_t_v[k+1] <= 1'b0;
            end else begin
                r_t_v[k+1] <= r_t_v[k];
            end
            if (r_t_n[k] >= w_trial) begin
                r_t_n[k+1] <= r_t_n[k] - w_trial;
                r_t_r[k+1] <= (r_t_r[k] >> 1) + BITV;
            end else begin
                r_t_n[k+1] <= r_t_n[k];
                r_t_r[k+1] <= r_t_r[k] >> 1;
            end
            r_t_m[k+1]    <= r_t_m[k];
            r_t_neg[k+1]  <= r_t_neg[k];
            r_t_side[k+1] <= r_t_side[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v[0] <= 1'b0;
        end else begin
            r_d_v[0] <= r_t_v[SQRT_STAGES];
        end
        r_d_s[0] <= r_t_r[SQRT_STAGES][31:0];
        for (int i = 0; i < 3; i++) begin
            r_d_num[0][i] <= {r_t_m[SQRT_STAGES][i], {FRAC_BITS{1'b0}}}
                             + t_num'(r_t_r[SQRT_STAGES][31:1]);
            r_d_rem[0][i] <= 32'd0;
            r_d_quo[0][i] <= '0;
        end
        r_d_neg[0]  <= r_t_neg[SQRT_STAGES];
        r_d_side[0] <= r_t_side[SQRT_STAGES];
    end

    // Restoring divide, one quotient bit per stage, three lanes sharing the divisor.
    for (genvar j = 0; j < DIV_W; j++) begin : g_div
        logic [2:0][32:0] w_sh;
        logic [2:0]       w_ge;
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_sh[i] = {r_d_rem[j][i], r_d_num[j][i][DIV_W-1-j]};
                w_ge[i] = w_sh[i] >= {1'b0, r_d_s[j]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_v[j+1] <= 1'b0;
            end else begin
                r_d_v[j+1] <= r_d_v[j];
            end
            for (int i = 0; i < 3; i++) begin
                r_d_rem[j+1][i] <= w_ge[i] ? 32'(w_sh[i] - {1'b0, r_d_s[j]}) : w_sh[i][31:0];
                r_d_quo[j+1][i] <= {r_d_quo[j][i][DIV_W-2:0], w_ge[i]};
            end
            r_d_s[j+1]    <= r_d_s[j];
            r_d_num[j+1]  <= r_d_num[j];
            r_d_neg[j+1]  <= r_d_neg[j];
            r_d_side[j+1] <= r_d_side[j];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [31:0] mag;
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= r_d_v[DIV_W];
        end
        for (int i = 0; i < 3; i++) begin
            if (|r_d_quo[DIV_W][i][DIV_W-1:31]) begin
                mag = 32'h7FFFFFFF;
            end else begin
                mag = r_d_quo[DIV_W][i][31:0];
            end
            if (r_d_s[DIV_W] == 32'd0) begin
                r_o_vec[i] <= '0;
            end else begin
                r_o_vec[i] <= r_d_neg[DIV_W][i] ? $signed(32'd0 - mag) : $signed(mag);
            end
        end
        r_o_side <= r_d_side[DIV_W];
    end

    assign o_valid = r_o_v;
    assign o_vec   = r_o_vec;
    assign o_side  = r_o_side;

endmodule

`default_nettype wire

// File: src/rod_frame_parallel_transport.sv
// Top level of the rod edge reference director transport pipeline.
//
// Usage: one rod edge is one transaction. An edge is accepted at each rising
// clock edge where start is high and busy is low. The block is fully
// pipelined, so busy stays low and a new edge may be sent in every cycle.
// Each edge carries the old reference director, the old and new unit tangents
// and the last-edge mark, all tangents and directors in signed Q1.14.
// Its result is held on the o_ ports for exactly one cycle with o_valid high:
// the transported first director, the second director (new tangent cross
// first director), the parallel flag and a copy of the last-edge mark.
// Results leave in acceptance order. The pipeline holds four normalizers
// of 82 stages each (a square stage, a sum stage, a 32 stage square root,
// a divider load stage, a 46 stage divider and an output stage) plus 22
// stages of products, dot products and cross products.
// Throughput is one edge per cycle at any fill level.
// The receiver cannot stall the block; a result must be taken when o_valid
// is high. Synchronous reset clears every valid bit, which drops all edges
// still in flight; datapath registers are not reset.
`default_nettype none

module rod_frame_parallel_transport import rfpt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_q16  i_dir_old_x,
    input  t_q16  i_dir_old_y,
    input  t_q16  i_dir_old_z,
    input  t_q16  i_tan_old_x,
    input  t_q16  i_tan_old_y,
    input  t_q16  i_tan_old_z,
    input  t_q16  i_tan_new_x,
    input  t_q16  i_tan_new_y,
    input  t_q16  i_tan_new_z,
    input  logic  i_last_edge,
    output logic  o_valid,
    output t_q16  o_dir1_new_x,
    output t_q16  o_dir1_new_y,
    output t_q16  o_dir1_new_z,
    output t_q16  o_dir2_new_x,
    output t_q16  o_dir2_new_y,
    output t_q16  o_dir2_new_z,
    output logic  o_tangents_parallel,
    output logic  o_last_edge_out
);

    // Input gathering and the exact axis t1 x t2.
    t_vec16 w_d, w_t1, w_t2;
    logic signed [32:0] w_bx [3];
    logic   r_a_v;
    t_vec32 r_a_b;
    t_side  r_a_side;

    // Normalizer and projection chain wiring.
    logic   w_ni_v    [4];
    t_vec32 w_ni_vec  [4];
    t_side  w_ni_side [4];
    logic   w_no_v    [4];
    t_vec32 w_no_vec  [4];
    t_side  w_no_side [4];
    logic   w_pi_v    [3];
    t_vec32 w_pi_vec  [3];
    t_side  w_pi_side [3];
    logic   w_po_v    [3];
    t_vec32 w_po_vec  [3];
    t_side  w_po_side [3];

    // Rotation stages.
    logic  r_c1_v;
    t_p48  r_c1_n1a [3];
    t_p48  r_c1_n1b [3];
    t_p48  r_c1_n2a [3];
    t_p48  r_c1_n2b [3];
    t_q32  r_c1_dt1 [3];
    t_p48  r_c1_db  [3];
    t_vec32 r_c1_b;
    t_side r_c1_side;

    logic   r_c2_v;
    t_vec32 r_c2_n1, r_c2_n2, r_c2_b;
    t_q32   r_c2_ka, r_c2_kc;
    t_side  r_c2_side;

    logic   r_c3_v;
    t_p48   r_c3_dn1 [3];
    t_vec32 r_c3_n2, r_c3_b;
    t_q32   r_c3_ka, r_c3_kc;
    t_side  r_c3_side;

    logic   r_c4_v;
    t_vec32 r_c4_n2, r_c4_b;
    t_q32   r_c4_ka, r_c4_kb, r_c4_kc;
    t_side  r_c4_side;

    logic   r_r1_v;
    t_p48   r_r1_a [3];
    t_p64   r_r1_b [3];
    t_p64   r_r1_c [3];
    t_side  r_r1_side;

    logic   r_r2_v;
    t_vec32 r_r2_vec;
    t_side  r_r2_side;

    // Output stages.
    logic   r_f1_v;
    t_vec16 r_f1_d1;
    t_side  r_f1_side;

    logic   r_f2_v;
    t_q32   r_f2_pa [3];
    t_q32   r_f2_pb [3];
    t_vec16 r_f2_d1;
    t_side  r_f2_side;

    logic   r_f3_v;
    t_vec16 r_f3_d1, r_f3_d2;
    logic   r_f3_par, r_f3_last;

    assign busy = 1'b0;

    assign w_d  = {i_dir_old_z, i_dir_old_y, i_dir_old_x};
    assign w_t1 = {i_tan_old_z, i_tan_old_y, i_tan_old_x};
    assign w_t2 = {i_tan_new_z, i_tan_new_y, i_tan_new_x};

    for (genvar gi = 0; gi < 3; gi++) begin : g_axis
        localparam int J = (gi + 1) % 3;
        localparam int K = (gi + 2) % 3;
        assign w_bx[gi] = $signed(w_t1[J]) * $signed(w_t2[K])
                        - $signed(w_t1[K]) * $signed(w_t2[J]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= start && !busy;
        end
        for (int i = 0; i < 3; i++) begin
            r_a_b[i] <= w_bx[i][31:0];
        end
        r_a_side.d    <= w_d;
        r_a_side.t1   <= w_t1;
        r_a_side.t2   <= w_t2;
        r_a_side.last <= i_last_edge;
        r_a_side.par  <= (w_bx[0] == '0) && (w_bx[1] == '0) && (w_bx[2] == '0);
    end

    // Chain: axis -> norm -> project on t1 -> norm -> project on t1, remove along t2
    // -> norm -> rotation -> project out t2 -> norm -> output.
    assign w_ni_v[0]    = r_a_v;
    assign w_ni_vec[0]  = r_a_b;
    assign w_ni_side[0] = r_a_side;
    assign w_ni_v[1]    = w_po_v[0];
    assign w_ni_vec[1]  = w_po_vec[0];
    assign w_ni_side[1] = w_po_side[0];
    assign w_ni_v[2]    = w_po_v[1];
    assign w_ni_vec[2]  = w_po_vec[1];
    assign w_ni_side[2] = w_po_side[1];
    assign w_ni_v[3]    = w_po_v[2];
    assign w_ni_vec[3]  = w_po_vec[2];
    assign w_ni_side[3] = w_po_side[2];

    assign w_pi_v[0]    = w_no_v[0];
    assign w_pi_vec[0]  = w_no_vec[0];
    assign w_pi_side[0] = w_no_side[0];
    assign w_pi_v[1]    = w_no_v[1];
    assign w_pi_vec[1]  = w_no_vec[1];
    assign w_pi_side[1] = w_no_side[1];
    assign w_pi_v[2]    = r_r2_v;
    assign w_pi_vec[2]  = r_r2_vec;
    assign w_pi_side[2] = r_r2_side;

    for (genvar n = 0; n < 4; n++) begin : g_norm
        rfpt_norm u_norm (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_ni_v[n]),
            .i_vec   (w_ni_vec[n]),
            .i_side  (w_ni_side[n]),
            .o_valid (w_no_v[n]),
            .o_vec   (w_no_vec[n]),
            .o_side  (w_no_side[n])
        );
    end

    // Projection: v - (v . a) c, four stages. The first uses a = c = t1, the
    // second a = t1 and c = t2, the third a = c = t2.
    for (genvar p = 0; p < 3; p++) begin : g_proj
        t_vec16 w_av, w_cv;
        logic   r_p1_v, r_p2_v, r_p3_v, r_p4_v;
        t_p48   r_p1_prod [3];
        t_p48   r_p3_prod [3];
        t_vec32 r_p1_vec, r_p2_vec, r_p3_vec, r_p4_vec;
        t_side  r_p1_side, r_p2_side, r_p3_side, r_p4_side;
        t_q32   r_p2_k;

        if (p == 2) begin : g_dot_t2
            assign w_av = w_pi_side[p].t2;
        end else begin : g_dot_t1
            assign w_av = w_pi_side[p].t1;
        end
        if (p == 0) begin : g_sub_t1
            assign w_cv = r_p2_side.t1;
        end else begin : g_sub_t2
            assign w_cv = r_p2_side.t2;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_p1_v <= 1'b0;
                r_p2_v <= 1'b0;
                r_p3_v <= 1'b0;
                r_p4_v <= 1'b0;
            end else begin
                r_p1_v <= w_pi_v[p];
                r_p2_v <= r_p1_v;
                r_p3_v <= r_p2_v;
                r_p4_v <= r_p3_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_p1_vec  <= w_pi_vec[p];
            r_p1_side <= w_pi_side[p];
            for (int i = 0; i < 3; i++) begin
                r_p1_prod[i] <= $signed(w_pi_vec[p][i]) * $signed(w_av[i]);
            end
        end

        always_ff @(posedge i_clk) begin
            r_p2_k    <= sat_int(rescale(64'(r_p1_prod[0]) + 64'(r_p1_prod[1])
                                         + 64'(r_p1_prod[2])));
            r_p2_vec  <= r_p1_vec;
            r_p2_side <= r_p1_side;
        end

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) begin
                r_p3_prod[i] <= r_p2_k * $signed(w_cv[i]);
            end
            r_p3_vec  <= r_p2_vec;
            r_p3_side <= r_p2_side;
        end

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) begin
                r_p4_vec[i] <= sat_int(64'($signed(r_p3_vec[i])) - rescale(64'(r_p3_prod[i])));
            end
            r_p4_side <= r_p3_side;
        end

        assign w_po_v[p]    = r_p4_v;
        assign w_po_vec[p]  = r_p4_vec;
        assign w_po_side[p] = r_p4_side;
    end

    // Rotation about the cleaned axis b: n1 = t1 x b, n2 = t2 x b and
    // r = (d.t1) t2 + (d.n1) n2 + (d.b) b.
    for (genvar gi = 0; gi < 3; gi++) begin : g_rot_cross
        localparam int J = (gi + 1) % 3;
        localparam int K = (gi + 2) % 3;
        always_ff @(posedge i_clk) begin
            r_c1_n1a[gi] <= $signed(w_no_side[2].t1[J]) * $signed(w_no_vec[2][K]);
            r_c1_n1b[gi] <= $signed(w_no_side[2].t1[K]) * $signed(w_no_vec[2][J]);
            r_c1_n2a[gi] <= $signed(w_no_side[2].t2[J]) * $signed(w_no_vec[2][K]);
            r_c1_n2b[gi] <= $signed(w_no_side[2].t2[K]) * $signed(w_no_vec[2][J]);
            r_c1_dt1[gi] <= $signed(w_no_side[2].d[gi]) * $signed(w_no_side[2].t1[gi]);
            r_c1_db[gi]  <= $signed(w_no_side[2].d[gi]) * $signed(w_no_vec[2][gi]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
            r_c3_v <= 1'b0;
            r_c4_v <= 1'b0;
            r_r1_v <= 1'b0;
            r_r2_v <= 1'b0;
        end else begin
            r_c1_v <= w_no_v[2];
            r_c2_v <= r_c1_v;
            r_c3_v <= r_c2_v;
            r_c4_v <= r_c3_v;
            r_r1_v <= r_c4_v;
            r_r2_v <= r_r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c1_b    <= w_no_vec[2];
        r_c1_side <= w_no_side[2];

        for (int i = 0; i < 3; i++) begin
            r_c2_n1[i] <= sat_int(rescale(64'(r_c1_n1a[i]) - 64'(r_c1_n1b[i])));
            r_c2_n2[i] <= sat_int(rescale(64'(r_c1_n2a[i]) - 64'(r_c1_n2b[i])));
        end
        r_c2_ka   <= sat_int(rescale(64'(r_c1_dt1[0]) + 64'(r_c1_dt1[1]) + 64'(r_c1_dt1[2])));
        r_c2_kc   <= sat_int(rescale(64'(r_c1_db[0]) + 64'(r_c1_db[1]) + 64'(r_c1_db[2])));
        r_c2_b    <= r_c1_b;
        r_c2_side <= r_c1_side;

        for (int i = 0; i < 3; i++) begin
            r_c3_dn1[i] <= $signed(r_c2_side.d[i]) * $signed(r_c2_n1[i]);
        end
        r_c3_n2   <= r_c2_n2;
        r_c3_b    <= r_c2_b;
        r_c3_ka   <= r_c2_ka;
        r_c3_kc   <= r_c2_kc;
        r_c3_side <= r_c2_side;

        r_c4_kb   <= sat_int(rescale(64'(r_c3_dn1[0]) + 64'(r_c3_dn1[1]) + 64'(r_c3_dn1[2])));
        r_c4_n2   <= r_c3_n2;
        r_c4_b    <= r_c3_b;
        r_c4_ka   <= r_c3_ka;
        r_c4_kc   <= r_c3_kc;
        r_c4_side <= r_c3_side;

        for (int i = 0; i < 3; i++) begin
            r_r1_a[i] <= r_c4_ka * $signed(r_c4_side.t2[i]);
            r_r1_b[i] <= r_c4_kb * $signed(r_c4_n2[i]);
            r_r1_c[i] <= r_c4_kc * $signed(r_c4_b[i]);
        end
        r_r1_side <= r_c4_side;

        for (int i = 0; i < 3; i++) begin
            r_r2_vec[i] <= sat_int(rescale(64'(r_r1_a[i])) + rescale(r_r1_b[i])
                                   + rescale(r_r1_c[i]));
        end
        r_r2_side <= r_r1_side;
    end

    // Output: pick the passed-through director when the tangents are parallel,
    // then form the second director from the saturated first one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
        end else begin
            r_f1_v <= w_no_v[3];
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_f1_d1[i] <= w_no_side[3].par ? sat_out(64'($signed(w_no_side[3].d[i])))
                                           : sat_out(64'($signed(w_no_vec[3][i])));
        end
        r_f1_side <= w_no_side[3];
    end

    for (genvar gi = 0; gi < 3; gi++) begin : g_out_cross
        localparam int J = (gi + 1) % 3;
        localparam int K = (gi + 2) % 3;
        always_ff @(posedge i_clk) begin
            r_f2_pa[gi] <= $signed(r_f1_side.t2[J]) * $signed(r_f1_d1[K]);
            r_f2_pb[gi] <= $signed(r_f1_side.t2[K]) * $signed(r_f1_d1[J]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_f2_d1   <= r_f1_d1;
        r_f2_side <= r_f1_side;
        for (int i = 0; i < 3; i++) begin
            r_f3_d2[i] <= sat_out(rescale(64'(r_f2_pa[i]) - 64'(r_f2_pb[i])));
        end
        r_f3_d1   <= r_f2_d1;
        r_f3_par  <= r_f2_side.par;
        r_f3_last <= r_f2_side.last;
    end

    assign o_valid             = r_f3_v;
    assign o_dir1_new_x        = r_f3_d1[0];
    assign o_dir1_new_y        = r_f3_d1[1];
    assign o_dir1_new_z        = r_f3_d1[2];
    assign o_dir2_new_x        = r_f3_d2[0];
    assign o_dir2_new_y        = r_f3_d2[1];
    assign o_dir2_new_z        = r_f3_d2[2];
    assign o_tangents_parallel = r_f3_par;
    assign o_last_edge_out     = r_f3_last;

`ifndef NO_ASSERTIONS
    // The x component of the first director and the z component of the second director stay within the output limit.
    a_dir_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_dir1_new_x) <= OUT_LIM) && ($signed(o_dir1_new_x) >= -OUT_LIM)
                 && ($signed(o_dir2_new_z) <= OUT_LIM) && ($signed(o_dir2_new_z) >= -OUT_LIM))
        else $error("director outside output limit");

    // The first normalizer never invents an item: each output matches an earlier input.
    a_norm_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_no_v[0] |-> $past(r_a_v, NORM_LAT))
        else $error("normalizer output without matching input");

    // An item in the first output stage reaches the ports through the second and third output stages.
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f1_v |-> ##2 o_valid)
        else $error("result lost in output stages");

    // The parallel flag is raised only when the registered axis is exactly zero.
    a_par_zero_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_v && r_a_side.par) |-> (r_a_b[0] == '0) && (r_a_b[1] == '0) && (r_a_b[2] == '0))
        else $error("parallel flag with nonzero axis");
`endif

endmodule

`default_nettype wire
